### design/ubrq_pkg.sv
// Package for the buffered uart rx/tx queue block.
// Holds the event codes, field widths and the ring control/status structs.
// No dependencies.
package ubrq_pkg;

  // field widths fixed by the item format
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned RX_COUNT_W = 3;
  localparam int unsigned TX_COUNT_W = 5;

  // event codes
  typedef enum logic [OP_W-1:0] {
    OP_HOST_PUT = 2'd0,
    OP_HOST_GET = 2'd1,
    OP_LINE_RX  = 2'd2,
    OP_TX_DONE  = 2'd3
  } op_t;

  // per-transaction commands to a ring
  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
  } ring_ctrl_t;

  // ring occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } ring_status_t;

endpackage

### design/ubrq_in_if.sv
// Input channel interface: one event per transaction.
// Depends on ubrq_pkg for the field widths.
interface ubrq_in_if;
  logic                         valid;
  logic                         ready;
  logic [ubrq_pkg::OP_W-1:0]    operation;
  logic [ubrq_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

### design/ubrq_out_if.sv
// Result channel interface: one result per event.
// Depends on ubrq_pkg for the field widths.
interface ubrq_out_if;
  logic                             valid;
  logic                             ready;
  logic [ubrq_pkg::BYTE_W-1:0]      line_byte;
  logic                             line_send;
  logic [ubrq_pkg::BYTE_W-1:0]      host_byte;
  logic                             host_valid;
  logic                             put_accepted;
  logic                             rx_dropped;
  logic [ubrq_pkg::RX_COUNT_W-1:0]  rx_count;
  logic [ubrq_pkg::TX_COUNT_W-1:0]  tx_count;
  logic                             transmitter_busy;

  modport source (
    output valid, output line_byte, output line_send, output host_byte,
    output host_valid, output put_accepted, output rx_dropped, output rx_count,
    output tx_count, output transmitter_busy, input ready
  );
  modport sink (
    input valid, input line_byte, input line_send, input host_byte,
    input host_valid, input put_accepted, input rx_dropped, input rx_count,
    input tx_count, input transmitter_busy, output ready
  );
endinterface

### design/ubrq_ring.sv
// Byte ring buffer with one slot kept empty, registered read of the head entry.
// Depends on ubrq_pkg for the control and status structs.
module ubrq_ring #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ubrq_pkg::ring_ctrl_t                  ctrl,
  input  logic [ubrq_pkg::BYTE_W-1:0]           push_data,
  output ubrq_pkg::ring_status_t                status,
  output logic [$clog2(DEPTH)-1:0]              count,
  output logic [ubrq_pkg::BYTE_W-1:0]           rd_data
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] count_r, count_nxt;
  logic [ubrq_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [ubrq_pkg::BYTE_W-1:0] rd_data_r;

  // wrap-around increment for any depth
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    logic [PW-1:0] res;
    if (p == PW'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + PW'(1);
    end
    return res;
  endfunction

  // flags from the occupancy count
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == PW'(DEPTH - 1));
  assign count        = count_r;
  assign rd_data      = rd_data_r;

  // pointer and count update
  always_comb begin
    head_nxt  = ctrl.pop  ? advance(head_r) : head_r;
    tail_nxt  = ctrl.push ? advance(tail_r) : tail_r;
    count_nxt = count_r;
    if (ctrl.push && !ctrl.pop) begin
      count_nxt = count_r + PW'(1);
    end else if (ctrl.pop && !ctrl.push) begin
      count_nxt = count_r - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail_r] <= push_data;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  // occupancy never reaches the reserved slot
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PW'(DEPTH - 1))
    else $error("ring count beyond capacity");

  // no push into a full ring
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |-> !status.full)
    else $error("push into full ring");

  // no pop from an empty ring
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !status.empty)
    else $error("pop from empty ring");

  // empty ring has coincident pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> (head_r == tail_r))
    else $error("empty ring with pointers apart");

endmodule

### design/uart_buffered_rx_tx_queues_core.sv
// Top level of the buffered uart rx/tx queue block.
// Depends on ubrq_pkg, ubrq_in_if, ubrq_out_if and ubrq_ring.
//
// Usage:
//   in_chan carries one event per transaction: host put, host get, line byte
//   received or line transmit done, with a data byte for put and receive.
//   out_chan returns exactly one result per event: the byte for the line and
//   its send strobe, the byte for the host and its valid flag, the put and
//   drop flags, both ring counts and the transmitter busy flag.
//   Latency: the result is valid in the cycle after the event is taken.
//   Throughput: one event per cycle; each event is a single pointer update
//   and at most one write to a ring store, with the head entry of each ring
//   read into a register alongside the result register.
//   Stall: while a result waits untaken, in_chan.ready stays low; it rises
//   in the same cycle the result is taken, so no bubble is added.
//   Reset: both rings are emptied, the transmitter is marked idle and no
//   result is pending. Ring contents are not cleared.
module uart_buffered_rx_tx_queues_core #(
  parameter int unsigned RX_DEPTH = 8,
  parameter int unsigned TX_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ubrq_in_if.sink     in_chan,
  ubrq_out_if.source  out_chan
);

  localparam int unsigned RXCW = $clog2(RX_DEPTH);
  localparam int unsigned TXCW = $clog2(TX_DEPTH);

  logic                  in_accept;
  ubrq_pkg::op_t         op;
  ubrq_pkg::ring_ctrl_t  rx_ctrl, tx_ctrl;
  ubrq_pkg::ring_status_t rx_status, tx_status;
  logic [RXCW-1:0]       rx_cnt;
  logic [TXCW-1:0]       tx_cnt;
  logic [ubrq_pkg::BYTE_W-1:0] rx_rd_data, tx_rd_data;

  logic [RXCW+ubrq_pkg::RX_COUNT_W-1:0] rx_cnt_ext;
  logic [TXCW+ubrq_pkg::TX_COUNT_W-1:0] tx_cnt_ext;

  // result register and transmitter state
  logic                        out_valid_r, out_valid_nxt;
  logic                        tx_busy_r, tx_busy_nxt;
  logic [ubrq_pkg::BYTE_W-1:0] data_r;
  logic                        line_direct_r, line_direct_nxt;
  logic                        line_ring_r, line_ring_nxt;
  logic                        host_valid_r, host_valid_nxt;
  logic                        put_acc_r, put_acc_nxt;
  logic                        rx_drop_r, rx_drop_nxt;

  assign in_accept     = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign op            = ubrq_pkg::op_t'(in_chan.operation);

  // event decode
  always_comb begin
    rx_ctrl         = '0;
    tx_ctrl         = '0;
    rx_ctrl.rd_en   = in_accept;
    tx_ctrl.rd_en   = in_accept;
    tx_busy_nxt     = tx_busy_r;
    line_direct_nxt = 1'b0;
    line_ring_nxt   = 1'b0;
    host_valid_nxt  = 1'b0;
    put_acc_nxt     = 1'b0;
    rx_drop_nxt     = 1'b0;
    if (in_accept) begin
      unique case (op)
        ubrq_pkg::OP_HOST_PUT: begin
          if (!tx_status.full) begin
            put_acc_nxt = 1'b1;
            if (tx_busy_r) begin
              tx_ctrl.push = 1'b1;
            end else begin
              line_direct_nxt = 1'b1;
              tx_busy_nxt     = 1'b1;
            end
          end
        end
        ubrq_pkg::OP_HOST_GET: begin
          if (!rx_status.empty) begin
            host_valid_nxt = 1'b1;
            rx_ctrl.pop    = 1'b1;
          end
        end
        ubrq_pkg::OP_LINE_RX: begin
          if (!rx_status.full) begin
            rx_ctrl.push = 1'b1;
          end else begin
            rx_drop_nxt = 1'b1;
          end
        end
        ubrq_pkg::OP_TX_DONE: begin
          if (!tx_status.empty) begin
            tx_ctrl.pop   = 1'b1;
            line_ring_nxt = 1'b1;
            tx_busy_nxt   = 1'b1;
          end else begin
            tx_busy_nxt = 1'b0;
          end
        end
        default: begin
          tx_busy_nxt = tx_busy_r;
        end
      endcase
    end
  end

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tx_busy_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      tx_busy_r   <= tx_busy_nxt;
    end
  end

  // result payload, loaded once per transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_r        <= in_chan.data_byte;
      line_direct_r <= line_direct_nxt;
      line_ring_r   <= line_ring_nxt;
      host_valid_r  <= host_valid_nxt;
      put_acc_r     <= put_acc_nxt;
      rx_drop_r     <= rx_drop_nxt;
    end
  end

  // receive ring
  ubrq_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (rx_ctrl),
    .push_data (in_chan.data_byte),
    .status    (rx_status),
    .count     (rx_cnt),
    .rd_data   (rx_rd_data)
  );

  // transmit ring
  ubrq_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (tx_ctrl),
    .push_data (in_chan.data_byte),
    .status    (tx_status),
    .count     (tx_cnt),
    .rd_data   (tx_rd_data)
  );

  // counts fitted to the result fields
  assign rx_cnt_ext = (RXCW + ubrq_pkg::RX_COUNT_W)'(rx_cnt);
  assign tx_cnt_ext = (TXCW + ubrq_pkg::TX_COUNT_W)'(tx_cnt);

  // result fields; ring state already reflects the last transaction
  assign out_chan.valid            = out_valid_r;
  assign out_chan.line_byte        = line_ring_r   ? tx_rd_data :
                                     line_direct_r ? data_r : '0;
  assign out_chan.line_send        = line_ring_r || line_direct_r;
  assign out_chan.host_byte        = host_valid_r ? rx_rd_data : '0;
  assign out_chan.host_valid       = host_valid_r;
  assign out_chan.put_accepted     = put_acc_r;
  assign out_chan.rx_dropped       = rx_drop_r;
  assign out_chan.rx_count         = rx_cnt_ext[ubrq_pkg::RX_COUNT_W-1:0];
  assign out_chan.tx_count         = tx_cnt_ext[ubrq_pkg::TX_COUNT_W-1:0];
  assign out_chan.transmitter_busy = tx_busy_r;

  // bytes only queue behind a busy transmitter
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_busy_r |-> tx_status.empty)
    else $error("transmit ring holds bytes while transmitter idle");

  // at most one of the event flags per result
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({host_valid_r, put_acc_r, rx_drop_r, line_ring_r}))
    else $error("conflicting result flags");

  // a byte sent to the line leaves the transmitter busy
  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (line_ring_r || line_direct_r)) |-> tx_busy_r)
    else $error("line send with transmitter idle");

  // a stalled result is held until taken
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> (!in_accept ##1 out_valid_r))
    else $error("stalled result dropped or overwritten");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for uart_buffered_rx_tx_queues_core: event traffic with a
// scoreboard that predicts both ring states and checks every result.
// Depends on ubrq_pkg, ubrq_in_if, ubrq_out_if and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BYTE_W        = ubrq_pkg::BYTE_W;
  localparam int unsigned RX_COUNT_W    = ubrq_pkg::RX_COUNT_W;
  localparam int unsigned TX_COUNT_W    = ubrq_pkg::TX_COUNT_W;
  localparam int unsigned RX_SLOTS      = 8;
  localparam int unsigned TX_SLOTS      = 32;
  localparam int unsigned RANDOM_EVENTS = 600;
  localparam int unsigned SEGMENT_LEN   = 50;
  localparam int unsigned IDLE_PERCENT  = 18;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // traffic mixes for the random part
  typedef enum int {MIX_UNIFORM, MIX_FILL_TX, MIX_FILL_RX, MIX_DRAIN} event_mix_t;

  // one result transaction, in the order of the result channel fields
  typedef struct packed {
    logic [BYTE_W-1:0]     line_byte;
    logic                  line_send;
    logic [BYTE_W-1:0]     host_byte;
    logic                  host_valid;
    logic                  put_accepted;
    logic                  rx_dropped;
    logic [RX_COUNT_W-1:0] rx_count;
    logic [TX_COUNT_W-1:0] tx_count;
    logic                  transmitter_busy;
  } uart_result_t;

  // predicts the ring pair and checks results in order
  class uart_queue_scoreboard;
    logic [BYTE_W-1:0]     rx_ring [RX_SLOTS];
    logic [BYTE_W-1:0]     tx_ring [TX_SLOTS];
    logic [RX_COUNT_W-1:0] rx_rd, rx_wr;
    logic [TX_COUNT_W-1:0] tx_rd, tx_wr;
    logic                  line_busy;
    uart_result_t          pending_q[$];
    int unsigned           errors;
    int unsigned           op_seen [4];
    int unsigned           rejected_puts, dropped_rx, empty_gets, tx_peak, rx_peak;

    function new();
      rx_rd = '0;
      rx_wr = '0;
      tx_rd = '0;
      tx_wr = '0;
      line_busy = 1'b0;
      errors = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
      rejected_puts = 0;
      dropped_rx = 0;
      empty_gets = 0;
      tx_peak = 0;
      rx_peak = 0;
    endfunction

    // occupancy in field width, wraps like the pointers
    function logic [RX_COUNT_W-1:0] rx_fill();
      return rx_wr - rx_rd;
    endfunction

    function logic [TX_COUNT_W-1:0] tx_fill();
      return tx_wr - tx_rd;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // accepted event: advance the prediction and queue its result
    function void note_event(ubrq_pkg::op_t op, logic [BYTE_W-1:0] data);
      uart_result_t r;
      r = '0;
      op_seen[op]++;
      case (op)
        ubrq_pkg::OP_HOST_PUT: begin
          if (tx_fill() == TX_COUNT_W'(TX_SLOTS - 1)) begin
            rejected_puts++;
          end else begin
            r.put_accepted = 1'b1;
            if (line_busy) begin
              tx_ring[tx_wr] = data;
              tx_wr++;
            end else begin
              // idle line takes the byte directly
              r.line_byte = data;
              r.line_send = 1'b1;
              line_busy = 1'b1;
            end
          end
        end
        ubrq_pkg::OP_HOST_GET: begin
          if (rx_fill() != '0) begin
            r.host_byte = rx_ring[rx_rd];
            r.host_valid = 1'b1;
            rx_rd++;
          end else begin
            empty_gets++;
          end
        end
        ubrq_pkg::OP_LINE_RX: begin
          if (rx_fill() == RX_COUNT_W'(RX_SLOTS - 1)) begin
            r.rx_dropped = 1'b1;
            dropped_rx++;
          end else begin
            rx_ring[rx_wr] = data;
            rx_wr++;
          end
        end
        default: begin
          // transmit done: next queued byte or go idle
          if (tx_fill() != '0) begin
            r.line_byte = tx_ring[tx_rd];
            r.line_send = 1'b1;
            tx_rd++;
            line_busy = 1'b1;
          end else begin
            line_busy = 1'b0;
          end
        end
      endcase
      r.rx_count = rx_fill();
      r.tx_count = tx_fill();
      r.transmitter_busy = line_busy;
      if (r.tx_count > tx_peak) tx_peak = r.tx_count;
      if (r.rx_count > rx_peak) rx_peak = r.rx_count;
      pending_q.push_back(r);
    endfunction

    // accepted result: compare field by field with the oldest prediction
    task check_result(uart_result_t got);
      uart_result_t want;
      if (pending_q.size() == 0) begin
        report("result with no event outstanding");
      end else begin
        want = pending_q.pop_front();
        if (got.line_byte !== want.line_byte)
          report($sformatf("line_byte %h, want %h", got.line_byte, want.line_byte));
        if (got.line_send !== want.line_send)
          report($sformatf("line_send %b, want %b", got.line_send, want.line_send));
        if (got.host_byte !== want.host_byte)
          report($sformatf("host_byte %h, want %h", got.host_byte, want.host_byte));
        if (got.host_valid !== want.host_valid)
          report($sformatf("host_valid %b, want %b", got.host_valid, want.host_valid));
        if (got.put_accepted !== want.put_accepted)
          report($sformatf("put_accepted %b, want %b", got.put_accepted, want.put_accepted));
        if (got.rx_dropped !== want.rx_dropped)
          report($sformatf("rx_dropped %b, want %b", got.rx_dropped, want.rx_dropped));
        if (got.rx_count !== want.rx_count)
          report($sformatf("rx_count %0d, want %0d", got.rx_count, want.rx_count));
        if (got.tx_count !== want.tx_count)
          report($sformatf("tx_count %0d, want %0d", got.tx_count, want.tx_count));
        if (got.transmitter_busy !== want.transmitter_busy)
          report($sformatf("transmitter_busy %b, want %b",
                           got.transmitter_busy, want.transmitter_busy));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;
  int unsigned cycle_count = 0;

  uart_queue_scoreboard sb = new();

  ubrq_in_if  in_ch ();
  ubrq_out_if out_ch ();

  uart_buffered_rx_tx_queues_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending_q.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result({out_ch.line_byte, out_ch.line_send, out_ch.host_byte,
                       out_ch.host_valid, out_ch.put_accepted, out_ch.rx_dropped,
                       out_ch.rx_count, out_ch.tx_count, out_ch.transmitter_busy});
    end
  end

  // present one event and hold it until the transaction completes
  task send_event(ubrq_pkg::op_t op, logic [BYTE_W-1:0] data);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= data;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_event(op, data);
    // random gap on the sending side
    if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // weighted event choice for each traffic mix
  function ubrq_pkg::op_t pick_op(event_mix_t mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL_TX:
        return roll < 85 ? ubrq_pkg::OP_HOST_PUT : roll < 90 ? ubrq_pkg::OP_TX_DONE :
               roll < 95 ? ubrq_pkg::OP_HOST_GET : ubrq_pkg::OP_LINE_RX;
      MIX_FILL_RX:
        return roll < 70 ? ubrq_pkg::OP_LINE_RX : roll < 85 ? ubrq_pkg::OP_HOST_GET :
               roll < 93 ? ubrq_pkg::OP_HOST_PUT : ubrq_pkg::OP_TX_DONE;
      MIX_DRAIN:
        return roll < 40 ? ubrq_pkg::OP_HOST_GET : roll < 80 ? ubrq_pkg::OP_TX_DONE :
               roll < 90 ? ubrq_pkg::OP_HOST_PUT : ubrq_pkg::OP_LINE_RX;
      default:
        return ubrq_pkg::op_t'(roll % 4);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [BYTE_W-1:0] rx_pattern [8];
    event_mix_t mix;
    rx_pattern = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h55, 8'haa, 8'h7f, 8'hfe};
    mix = MIX_UNIFORM;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= ubrq_pkg::OP_HOST_PUT;
    in_ch.data_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // transmit done and get while everything is empty
    send_event(ubrq_pkg::OP_TX_DONE, 8'h5a);
    send_event(ubrq_pkg::OP_HOST_GET, 8'hff);
    // put to idle line goes straight out, the next one is queued
    send_event(ubrq_pkg::OP_HOST_PUT, 8'h00);
    send_event(ubrq_pkg::OP_HOST_PUT, 8'hff);
    // done sends the queued byte, then the line goes idle
    send_event(ubrq_pkg::OP_TX_DONE, 8'h00);
    send_event(ubrq_pkg::OP_TX_DONE, 8'h00);
    // fill the receive ring past full, last byte is dropped
    for (int i = 0; i < 8; i++) send_event(ubrq_pkg::OP_LINE_RX, rx_pattern[i]);
    // drain it, last get finds it empty
    for (int i = 0; i < 8; i++) send_event(ubrq_pkg::OP_HOST_GET, 8'(i));

    // random traffic in segments of one mix each, with a stretch at full rate
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i % SEGMENT_LEN == 0) mix = event_mix_t'($urandom_range(3));
      quiet = (i >= 200 && i < 320);
      send_event(pick_op(mix), 8'($urandom_range(255)));
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    // let every result drain, then a few more cycles
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d puts (%0d rejected), %0d gets (%0d empty), %0d rx (%0d dropped),",
             sb.op_seen[ubrq_pkg::OP_HOST_PUT], sb.rejected_puts,
             sb.op_seen[ubrq_pkg::OP_HOST_GET], sb.empty_gets,
             sb.op_seen[ubrq_pkg::OP_LINE_RX], sb.dropped_rx);
    $display("%0d transmit done; peak tx fill %0d, peak rx fill %0d; %0d mismatches",
             sb.op_seen[ubrq_pkg::OP_TX_DONE], sb.tx_peak, sb.rx_peak, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
